/* rtl/core/bplfm_pkg.sv */
// shared types and codes of the buffer pool frame manager
`default_nettype none
package bplfm_pkg;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAP,
      S_REC,
      S_EXEC,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      LNK_NONE,
      LNK_REMOVE,
      LNK_APPEND
   } link_op_type;

   localparam logic [1:0] MODE_FETCH  = 2'd0;
   localparam logic [1:0] MODE_UNPIN  = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_NOTRES   = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_UNPINNED = 3'd3;
   localparam logic [2:0] STAT_LIMIT    = 3'd4;

   localparam logic [7:0] PIN_MAX = 8'd255;

endpackage
`default_nettype wire

/* rtl/core/buffer_pool_lru_frame_manager_unit.sv */
// buffer pool frame manager top level: page table, frame records, unpin order list
//
// req channel: one beat per operation (fetch, unpin, flush) with page and mark_dirty.
// rsp channel: exactly one beat per request, in request order.
// a request passes the states map, rec, exec and done between its accept and its
// response beat; one request is worked on at a time, so no new request is taken
// before the last one has left done. the steps follow the chain of dependent memory
// reads: page table, then frame record, then the unpin order links, then the write back.
// the result sits in an output register; the next request is taken while it waits.
// if the receiver stalls, a finished result waits in a holding register until the
// output register frees, and no further request is accepted meanwhile.
// reset (synchronous) empties the pool at once: no clearing pass. residency is
// proven by checking the frame record against the page, and a frame counts as in
// use only once it was handed out (frames go out from the highest number down),
// so the memories need no initial contents.
// the unpin order is a doubly linked list over frames (next/prev memories) with
// head, tail and count registers: head is the frame unpinned longest ago.
`default_nettype none
module buffer_pool_lru_frame_manager_unit
   import bplfm_pkg::*;
#(
   parameter int FRAMES = 64,
   parameter int PAGES  = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [9:0]  req_page,
   input  wire logic        req_mark_dirty,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [5:0]       rsp_frame,
   output logic             rsp_hit,
   output logic             rsp_load_request,
   output logic             rsp_writeback_request,
   output logic [9:0]       rsp_writeback_page
);

   localparam int FW  = $clog2(FRAMES);
   localparam int FLW = $clog2(FRAMES + 1);
   localparam int PAW = $clog2(PAGES);
   localparam int RW  = PAW + 9;   // record: page, pins, dirty

   // memories
   logic [FW-1:0]  p2f_mem [PAGES];
   logic [RW-1:0]  rec_mem [FRAMES];
   logic [FW-1:0]  nxt_mem [FRAMES];
   logic [FW-1:0]  prv_mem [FRAMES];

   logic [FW-1:0]  p2f_rd;
   logic [RW-1:0]  rec_rd;
   logic [FW-1:0]  nxt_rd;
   logic [FW-1:0]  prv_rd;
   logic [FW-1:0]  rec_ra;

   // control state
   state_type      state_ff, state_in;
   logic [FLW-1:0] free_ff, count_ff;
   logic [FW-1:0]  head_ff, tail_ff;

   // request latch
   logic [1:0]     mode_ff;
   logic [9:0]     page_ff;
   logic           mark_ff;
   logic [FW-1:0]  f_ff;
   logic           f_ok_ff;

   // plan made from the frame record
   logic           pl_rec_we, pl_rec_we_ff;
   logic [RW-1:0]  pl_wd, pl_wd_ff;
   logic           pl_p2f_we, pl_p2f_we_ff;
   link_op_type    pl_lop, pl_lop_ff;
   logic [FW-1:0]  pl_lx, pl_lx_ff;
   logic [FW-1:0]  pl_f, pl_f_ff;
   logic           pl_victim, pl_victim_ff;
   logic           pl_free_dec, pl_free_dec_ff;
   logic [2:0]     pl_status;
   logic           pl_hit, pl_load, pl_wb;
   logic [9:0]     pl_wbp;
   logic [FW-1:0]  pl_frame;

   // result holding register
   logic [2:0]     res_status_ff;
   logic [FW-1:0]  res_frame_ff;
   logic           res_hit_ff, res_load_ff, res_wb_ff;
   logic [9:0]     res_wbp_ff;

   logic           rsp_valid_ff;
   logic [2:0]     rsp_status_ff;
   logic [5:0]     rsp_frame_ff;
   logic           rsp_hit_ff, rsp_load_ff, rsp_wb_ff;
   logic [9:0]     rsp_wbp_ff;

   logic           accept;
   logic           slot_free;
   logic           load_rsp;

   // record fields as read
   logic [PAW-1:0] rec_page;
   logic [7:0]     rec_pins;
   logic           rec_dirty;
   logic           in_range;
   logic           resident;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign rec_page  = rec_rd[RW-1:9];
   assign rec_pins  = rec_rd[8:1];
   assign rec_dirty = rec_rd[0];

   // ---------------------------------------------------------------- memories
   // page table: read at the incoming page, written when a page is loaded
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC && pl_p2f_we_ff) begin
         p2f_mem[PAW'(page_ff)] <= pl_f_ff;
      end
      p2f_rd <= p2f_mem[PAW'(req_page)];
   end

   // frame record: resident frame first, then the head frame for a victim
   assign rec_ra = (state_ff == S_MAP) ? p2f_rd : head_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC && pl_rec_we_ff) begin
         rec_mem[pl_f_ff] <= pl_wd_ff;
      end
      rec_rd <= rec_mem[rec_ra];
   end

   // unpin order links
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         if (pl_lop_ff == LNK_REMOVE) begin
            if (pl_lx_ff != head_ff) begin
               nxt_mem[prv_rd] <= nxt_rd;
            end
            if (pl_lx_ff != tail_ff) begin
               prv_mem[nxt_rd] <= prv_rd;
            end
         end else if (pl_lop_ff == LNK_APPEND && count_ff != '0) begin
            nxt_mem[tail_ff]  <= pl_lx_ff;
            prv_mem[pl_lx_ff] <= tail_ff;
         end
      end
      nxt_rd <= nxt_mem[pl_lx];
      prv_rd <= prv_mem[pl_lx];
   end

   // ---------------------------------------------------------------- decision
   assign in_range = 32'(page_ff) < PAGES;
   assign resident = in_range && f_ok_ff && (FLW'(f_ff) >= free_ff)
                     && (rec_page == PAW'(page_ff));

   always_comb begin
      pl_rec_we   = 1'b0;
      pl_wd       = rec_rd;
      pl_p2f_we   = 1'b0;
      pl_lop      = LNK_NONE;
      pl_lx       = f_ff;
      pl_f        = f_ff;
      pl_victim   = 1'b0;
      pl_free_dec = 1'b0;
      pl_status   = STAT_OK;
      pl_hit      = 1'b0;
      pl_load     = 1'b0;
      pl_wb       = 1'b0;
      pl_wbp      = '0;
      pl_frame    = '0;
      case (mode_ff)
         MODE_FETCH: begin
            if (!in_range) begin
               pl_status = STAT_NOTRES;
            end else if (resident) begin
               pl_hit   = 1'b1;
               pl_frame = f_ff;
               if (rec_pins == PIN_MAX) begin
                  pl_status = STAT_LIMIT;
               end else begin
                  pl_rec_we = 1'b1;
                  pl_wd     = {rec_page, rec_pins + 8'd1, rec_dirty};
                  if (rec_pins == 8'd0) begin
                     pl_lop = LNK_REMOVE;
                  end
               end
            end else if (free_ff != '0) begin
               // take the highest free frame
               pl_f        = FW'(free_ff - FLW'(1));
               pl_free_dec = 1'b1;
               pl_rec_we   = 1'b1;
               pl_wd       = {PAW'(page_ff), 8'd1, 1'b0};
               pl_p2f_we   = 1'b1;
               pl_load     = 1'b1;
               pl_frame    = pl_f;
            end else if (count_ff != '0) begin
               // evict the frame unpinned longest ago
               pl_f      = head_ff;
               pl_lx     = head_ff;
               pl_lop    = LNK_REMOVE;
               pl_victim = 1'b1;
               pl_rec_we = 1'b1;
               pl_wd     = {PAW'(page_ff), 8'd1, 1'b0};
               pl_p2f_we = 1'b1;
               pl_load   = 1'b1;
               pl_frame  = head_ff;
            end else begin
               pl_status = STAT_FULL;
            end
         end
         MODE_UNPIN: begin
            if (resident) begin
               pl_frame = f_ff;
               if (rec_pins == 8'd0) begin
                  pl_status = STAT_UNPINNED;
               end else begin
                  pl_rec_we = 1'b1;
                  pl_wd     = {rec_page, rec_pins - 8'd1, rec_dirty | mark_ff};
                  if (rec_pins == 8'd1) begin
                     pl_lop = LNK_APPEND;
                  end
               end
            end else begin
               pl_status = STAT_NOTRES;
            end
         end
         MODE_FLUSH: begin
            if (resident) begin
               pl_frame  = f_ff;
               pl_wb     = 1'b1;
               pl_wbp    = page_ff;
               pl_rec_we = 1'b1;
               pl_wd     = {rec_page, rec_pins, 1'b0};
            end else begin
               pl_status = STAT_NOTRES;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_MAP;
         S_MAP:   state_in = S_REC;
         S_REC:   state_in = S_EXEC;
         S_EXEC:  state_in = S_DONE;
         S_DONE:  if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         S_IDLE:  req_ready = !reset;
         S_DONE:  load_rsp  = slot_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request latch and page table lookup result
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         page_ff <= req_page;
         mark_ff <= req_mark_dirty;
      end
      if (state_ff == S_MAP) begin
         f_ff    <= p2f_rd;
         f_ok_ff <= 32'(p2f_rd) < FRAMES;
      end
   end

   // plan register
   always_ff @(posedge clock) begin
      if (state_ff == S_REC) begin
         pl_rec_we_ff   <= pl_rec_we;
         pl_wd_ff       <= pl_wd;
         pl_p2f_we_ff   <= pl_p2f_we;
         pl_lop_ff      <= pl_lop;
         pl_lx_ff       <= pl_lx;
         pl_f_ff        <= pl_f;
         pl_victim_ff   <= pl_victim;
         pl_free_dec_ff <= pl_free_dec;
         res_status_ff  <= pl_status;
         res_frame_ff   <= pl_frame;
         res_hit_ff     <= pl_hit;
         res_load_ff    <= pl_load;
         res_wb_ff      <= pl_wb;
         res_wbp_ff     <= pl_wbp;
      end else if (state_ff == S_EXEC && pl_victim_ff) begin
         // old page of the victim goes out only if dirty
         res_wb_ff  <= rec_dirty;
         res_wbp_ff <= rec_dirty ? 10'(rec_page) : 10'd0;
      end
   end

   // pool bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= FLW'(FRAMES);
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else if (state_ff == S_EXEC) begin
         if (pl_free_dec_ff) begin
            free_ff <= free_ff - FLW'(1);
         end
         if (pl_lop_ff == LNK_REMOVE) begin
            count_ff <= count_ff - FLW'(1);
            if (pl_lx_ff == head_ff) head_ff <= nxt_rd;
            if (pl_lx_ff == tail_ff) tail_ff <= prv_rd;
         end else if (pl_lop_ff == LNK_APPEND) begin
            count_ff <= count_ff + FLW'(1);
            tail_ff  <= pl_lx_ff;
            if (count_ff == '0) head_ff <= pl_lx_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_frame_ff  <= 6'(res_frame_ff);
         rsp_hit_ff    <= res_hit_ff;
         rsp_load_ff   <= res_load_ff;
         rsp_wb_ff     <= res_wb_ff;
         rsp_wbp_ff    <= res_wbp_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_frame             = rsp_frame_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_load_request      = rsp_load_ff;
   assign rsp_writeback_request = rsp_wb_ff;
   assign rsp_writeback_page    = rsp_wbp_ff;

   // ---------------------------------------------------------------- checks
   // unpinned frames are all frames already handed out
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= FRAMES - 32'(free_ff))
      else $error("unpin order longer than frames in use");

   // all frames pinned is only answered once no free frame is left
   a_full_no_free : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_FULL |-> free_ff == '0)
      else $error("all-pinned answer while free frames remain");

   // an accepted beat starts the lookup
   a_accept_map : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MAP)
      else $error("accepted request not looked up");

endmodule
`default_nettype wire

/* tb/buffer_pool_lru_frame_manager_unit_tb.sv */
// testbench of the buffer pool frame manager: directed table, then random traffic
module buffer_pool_lru_frame_manager_unit_tb
   import bplfm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAMES = 64;
   localparam int PAGES  = 1024;
   localparam int RANDOM_ITEMS = 124;

   // one response beat
   typedef struct packed {
      logic [2:0] status;
      logic [5:0] frame;
      logic       hit;
      logic       load;
      logic       wb;
      logic [9:0] wb_page;
   } answer_type;

   // one row of the directed table; reps beats, page advancing by step
   typedef struct {
      logic [1:0] mode;
      logic [9:0] page;
      logic       dirty;
      int         reps;
      int         step;
      bit         typed;
      answer_type answer;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = '0;
   logic [9:0] req_page = '0;
   logic       req_mark_dirty = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [5:0] rsp_frame;
   logic       rsp_hit;
   logic       rsp_load_request;
   logic       rsp_writeback_request;
   logic [9:0] rsp_writeback_page;

   buffer_pool_lru_frame_manager_unit dut (.*);

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the pool
   bit         map_valid [PAGES];
   logic [5:0] map_frame [PAGES];
   bit         holds_page [FRAMES];
   logic [9:0] frame_owner [FRAMES];
   logic [7:0] frame_pin_cnt [FRAMES];
   bit         frame_modified [FRAMES];
   int         lru_order [$];   // unpinned frames, oldest first
   int         free_left;

   answer_type pool_answers_q [$];
   row_type    table_rows [$];
   int         fail_count = 0;
   int         idle_pct = 0;
   int         stall_pct = 0;

   function automatic void lru_drop(int f);
      foreach (lru_order[i]) begin
         if (lru_order[i] == f) begin
            lru_order.delete(i);
            return;
         end
      end
   endfunction

   // computes the answer to one request and updates the shadow pool
   function automatic answer_type pool_lookup(logic [1:0] mode, logic [9:0] page,
                                              logic dirty);
      answer_type a;
      bit res;
      int f;
      a = '0;
      res = map_valid[page];
      f = res ? map_frame[page] : 0;
      if (mode == MODE_FETCH) begin
         if (res) begin
            a.hit = 1'b1;
            a.frame = 6'(f);
            if (frame_pin_cnt[f] == PIN_MAX) begin
               a.status = STAT_LIMIT;
            end else begin
               if (frame_pin_cnt[f] == 0) lru_drop(f);
               frame_pin_cnt[f]++;
            end
         end else if (free_left == 0 && lru_order.size() == 0) begin
            a.status = STAT_FULL;
         end else begin
            if (free_left > 0) begin
               free_left--;
               f = free_left;
            end else begin
               f = lru_order.pop_front();
               if (holds_page[f]) begin
                  // victim: write back only when modified
                  if (frame_modified[f]) begin
                     a.wb = 1'b1;
                     a.wb_page = frame_owner[f];
                  end
                  map_valid[frame_owner[f]] = 0;
               end
            end
            holds_page[f] = 1;
            frame_owner[f] = page;
            frame_pin_cnt[f] = 1;
            frame_modified[f] = 0;
            map_valid[page] = 1;
            map_frame[page] = 6'(f);
            a.frame = 6'(f);
            a.load = 1'b1;
         end
      end else if (mode == MODE_UNPIN) begin
         if (!res) begin
            a.status = STAT_NOTRES;
         end else if (frame_pin_cnt[f] == 0) begin
            a.status = STAT_UNPINNED;
            a.frame = 6'(f);
         end else begin
            a.frame = 6'(f);
            frame_pin_cnt[f]--;
            if (dirty) frame_modified[f] = 1;
            if (frame_pin_cnt[f] == 0) lru_order.push_back(f);
         end
      end else if (mode == MODE_FLUSH) begin
         if (!res) begin
            a.status = STAT_NOTRES;
         end else begin
            // clean pages are written back too
            a.frame = 6'(f);
            a.wb = 1'b1;
            a.wb_page = page;
            frame_modified[f] = 0;
         end
      end
      return a;
   endfunction

   // presents one beat, starting at a falling edge, and books its answer
   task automatic send_beat(logic [1:0] mode, logic [9:0] page, logic dirty,
                            bit typed, answer_type typed_answer);
      answer_type a;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_page <= page;
      req_mark_dirty <= dirty;
      do @(posedge clock); while (!req_ready);
      a = pool_lookup(mode, page, dirty);
      pool_answers_q.push_back(typed ? typed_answer : a);
      @(negedge clock);
   endtask

   function automatic row_type mk(logic [1:0] m, logic [9:0] p, logic d, int reps,
                                  int step, bit typed, answer_type a);
      row_type r;
      r.mode = m; r.page = p; r.dirty = d; r.reps = reps; r.step = step;
      r.typed = typed; r.answer = a;
      return r;
   endfunction

   // receiver stalls, changed at the falling edge
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // response checker
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_frame, rsp_hit, rsp_load_request,
                 rsp_writeback_request, rsp_writeback_page};
         if (pool_answers_q.size() == 0) begin
            $display("%0t: unexpected beat %p", $realtime, got);
            fail_count++;
         end else begin
            want = pool_answers_q.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
               fail_count++;
            end
            if (got.frame !== want.frame) begin
               $display("%0t: frame exp %0d got %0d", $realtime, want.frame, got.frame);
               fail_count++;
            end
            if (got.hit !== want.hit) begin
               $display("%0t: hit exp %0d got %0d", $realtime, want.hit, got.hit);
               fail_count++;
            end
            if (got.load !== want.load) begin
               $display("%0t: load exp %0d got %0d", $realtime, want.load, got.load);
               fail_count++;
            end
            if (got.wb !== want.wb) begin
               $display("%0t: writeback exp %0d got %0d", $realtime, want.wb, got.wb);
               fail_count++;
            end
            if (got.wb_page !== want.wb_page) begin
               $display("%0t: writeback page exp %0d got %0d", $realtime,
                        want.wb_page, got.wb_page);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      answer_type none;
      logic [1:0] m;
      logic [9:0] p;
      int r;
      int wait_cycles;
      none = '0;
      free_left = FRAMES;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      table_rows.push_back(mk(MODE_UNPIN, 10'd5, 1'b1, 1, 0, 1, '{STAT_NOTRES, 0, 0, 0, 0, 0}));
      table_rows.push_back(mk(MODE_FLUSH, 10'd1023, 1'b0, 1, 0, 1,
                              '{STAT_NOTRES, 0, 0, 0, 0, 0}));
      table_rows.push_back(mk(MODE_UNUSED, 10'd7, 1'b1, 1, 0, 1, '{STAT_OK, 0, 0, 0, 0, 0}));
      // first miss after reset goes to the top frame
      table_rows.push_back(mk(MODE_FETCH, 10'd0, 1'b0, 1, 0, 1, '{STAT_OK, 63, 0, 1, 0, 0}));
      table_rows.push_back(mk(MODE_FETCH, 10'd0, 1'b0, 254, 0, 0, none));
      // pin count saturated
      table_rows.push_back(mk(MODE_FETCH, 10'd0, 1'b0, 1, 0, 1, '{STAT_LIMIT, 63, 1, 0, 0, 0}));
      table_rows.push_back(mk(MODE_FETCH, 10'd1, 1'b0, 63, 1, 0, none));
      // every frame pinned
      table_rows.push_back(mk(MODE_FETCH, 10'd512, 1'b0, 1, 0, 1, '{STAT_FULL, 0, 0, 0, 0, 0}));
      table_rows.push_back(mk(MODE_UNPIN, 10'd1, 1'b1, 1, 0, 0, none));
      table_rows.push_back(mk(MODE_UNPIN, 10'd1, 1'b0, 1, 0, 1,
                              '{STAT_UNPINNED, 62, 0, 0, 0, 0}));
      table_rows.push_back(mk(MODE_FLUSH, 10'd2, 1'b0, 1, 0, 0, none));
      table_rows.push_back(mk(MODE_FETCH, 10'd700, 1'b0, 1, 0, 0, none));

      foreach (table_rows[i]) begin
         for (int k = 0; k < table_rows[i].reps; k++) begin
            send_beat(table_rows[i].mode, 10'(table_rows[i].page + k * table_rows[i].step),
                      table_rows[i].dirty, table_rows[i].typed, table_rows[i].answer);
         end
      end

      // random traffic in four phases with different idle and stall rates
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            r = $urandom_range(99);
            if (r < 40) m = MODE_FETCH;
            else if (r < 85) m = MODE_UNPIN;
            else if (r < 95) m = MODE_FLUSH;
            else m = MODE_UNUSED;
            // mostly a working set a bit larger than the pool, to force evictions
            p = ($urandom_range(99) < 85) ? 10'($urandom_range(90)) : 10'($urandom_range(1023));
            send_beat(m, p, 1'($urandom_range(1)), 0, none);
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pool_answers_q.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pool_answers_q.size() != 0) begin
         $display("%0t: %0d beats never answered", $realtime, pool_answers_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
